### hdl/lcs_pkg.sv
// Shared types, constants and item formats for the longest common subsequence engine.
package lcs_pkg;

    localparam int MAX_LEN = 64;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int SCORE_W = LEN_W;
    localparam int SYM_W   = 8;
    localparam int T_W     = LEN_W + 1;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    typedef enum logic [1:0] {
        DIR_MATCH  = 2'd0,
        DIR_FIRST  = 2'd1,
        DIR_SECOND = 2'd2
    } dir_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [SYM_W-1:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic             last;
        logic             empty_res;
        logic             truncated;
    } out_item_t;

    // What one cell hands to its right-hand neighbour every cycle.
    typedef struct packed {
        logic               valid;
        logic [SYM_W-1:0]   sym;
        logic [IDX_W-1:0]   row;
        logic [SCORE_W-1:0] score;
        logic [SCORE_W-1:0] diag;
    } link_t;

endpackage

### hdl/lcs_cell.sv
// One column cell of the score wavefront, with its column of direction marks.
module lcs_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clr,
    input  lcs_pkg::link_t              lin,
    input  logic                        b_we,
    input  logic [lcs_pkg::SYM_W-1:0]   b_data,
    input  logic [lcs_pkg::IDX_W-1:0]   rd_addr,
    output lcs_pkg::link_t              lout,
    output lcs_pkg::dir_t               dir_rd,
    output logic [lcs_pkg::SCORE_W-1:0] score
);
    import lcs_pkg::*;

    logic [SYM_W-1:0]   b_reg;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] diag_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [IDX_W-1:0]   row_reg;
    logic               valid_reg;
    logic               valid_next;
    dir_t               dir_mem [MAX_LEN];
    dir_t               dir_rd_reg;
    logic [SCORE_W-1:0] new_score;
    dir_t               new_dir;

    always_comb
    begin
        if (lin.sym == b_reg)
        begin
            new_dir   = DIR_MATCH;
            new_score = lin.diag + SCORE_W'(1);
        end
        else if (score_reg < lin.score)
        begin
            new_dir   = DIR_SECOND;
            new_score = lin.score;
        end
        else
        begin
            new_dir   = DIR_FIRST;
            new_score = score_reg;
        end
    end

    assign valid_next = lin.valid && !clr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_reg <= b_data;
        end
        if (clr)
        begin
            score_reg <= '0;
        end
        else if (lin.valid)
        begin
            score_reg <= new_score;
            diag_reg  <= score_reg;
            dir_mem[lin.row] <= new_dir;
        end
        sym_reg    <= lin.sym;
        row_reg    <= lin.row;
        dir_rd_reg <= dir_mem[rd_addr];
    end

    always_comb
    begin
        lout.valid = valid_reg;
        lout.sym   = sym_reg;
        lout.row   = row_reg;
        lout.score = score_reg;
        lout.diag  = diag_reg;
    end

    assign dir_rd = dir_rd_reg;
    assign score  = score_reg;

endmodule

### hdl/longest_common_subsequence_top.sv
// Top level of the longest common subsequence engine: loading, wavefront, traceback, output.
// Sequence: a load item is taken while idle. A compute item with strings of length LA and LB
// runs through the cell row in the fill state, then each traceback step has a read and a step
// state (at most LA + LB steps), then each result item an emit read, emit put and hold state.
// Throughput: one item at a time; input is stalled from compute until its last result leaves.
// Reset clears lengths, the overflow flag and all control; string and table stores need none.
module longest_common_subsequence_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lcs_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output lcs_pkg::out_item_t out_item
);
    import lcs_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_FILL     = 7'b0000010,
        ST_TR_RD    = 7'b0000100,
        ST_TR_STEP  = 7'b0001000,
        ST_EMIT_RD  = 7'b0010000,
        ST_EMIT_PUT = 7'b0100000,
        ST_HOLD     = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   la_reg, la_next;
    logic [LEN_W-1:0]   lb_reg, lb_next;
    logic               ovf_reg, ovf_next;
    logic [T_W-1:0]     t_reg, t_next;
    logic [IDX_W-1:0]   ti_reg, ti_next;
    logic [IDX_W-1:0]   tj_reg, tj_next;
    logic [LEN_W-1:0]   k_reg, k_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   emit_idx_reg, emit_idx_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;
    logic               feed_valid_reg, feed_valid_next;
    logic [IDX_W-1:0]   feed_row_reg;

    // The first string and the answer are small memories with registered reads.
    logic [SYM_W-1:0]   a_mem [MAX_LEN];
    logic [SYM_W-1:0]   ans_mem [MAX_LEN];
    logic [SYM_W-1:0]   a_rd_data_reg;
    logic [SYM_W-1:0]   ans_rd_data_reg;
    logic [IDX_W-1:0]   a_rd_addr;
    logic               a_we;
    logic               b_we;
    logic               ans_we;
    logic [IDX_W-1:0]   ans_wr_addr;
    logic               clr;
    logic               accept;

    link_t              feed;
    link_t              links  [MAX_LEN];
    dir_t               dirs   [MAX_LEN];
    logic [SCORE_W-1:0] scores [MAX_LEN];
    logic [T_W-1:0]     fill_end;
    dir_t               cur_dir;
    logic [SCORE_W-1:0] final_score;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign fill_end = T_W'(la_reg) + T_W'(lb_reg);
    assign cur_dir  = dirs[tj_reg];
    assign final_score = scores[IDX_W'(lb_reg - LEN_W'(1))];
    assign a_rd_addr = (state_reg == ST_FILL) ? t_reg[IDX_W-1:0] : ti_reg;

    // Row symbols of the first string enter the left end of the cell row one per cycle;
    // each cell then works one row behind its left neighbour.
    assign feed_valid_next = (state_reg == ST_FILL) && (t_reg < T_W'(la_reg));

    always_comb
    begin
        feed.valid = feed_valid_reg;
        feed.sym   = a_rd_data_reg;
        feed.row   = feed_row_reg;
        feed.score = '0;
        feed.diag  = '0;
    end

    for (genvar g = 0; g < MAX_LEN; g++)
    begin : g_cell
        logic  cell_b_we;
        link_t cell_in;

        assign cell_b_we = b_we && (lb_reg[IDX_W-1:0] == IDX_W'(g));

        if (g == 0)
        begin : g_first
            assign cell_in = feed;
        end
        else
        begin : g_rest
            assign cell_in = links[g-1];
        end

        lcs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clr     (clr),
            .lin     (cell_in),
            .b_we    (cell_b_we),
            .b_data  (in_item.symbol),
            .rd_addr (ti_reg),
            .lout    (links[g]),
            .dir_rd  (dirs[g]),
            .score   (scores[g])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        la_next        = la_reg;
        lb_next        = lb_reg;
        ovf_next       = ovf_reg;
        t_next         = t_reg;
        ti_next        = ti_reg;
        tj_next        = tj_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        a_we           = 1'b0;
        b_we           = 1'b0;
        ans_we         = 1'b0;
        ans_wr_addr    = IDX_W'(k_reg - LEN_W'(1));
        clr            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_item.opcode)
                        OP_LOAD_A:
                        begin
                            if (la_reg < LEN_W'(MAX_LEN))
                            begin
                                a_we    = 1'b1;
                                la_next = la_reg + LEN_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_LOAD_B:
                        begin
                            if (lb_reg < LEN_W'(MAX_LEN))
                            begin
                                b_we    = 1'b1;
                                lb_next = lb_reg + LEN_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_COMPUTE:
                        begin
                            if ((la_reg == '0) || (lb_reg == '0))
                            begin
                                out_item_next.out_symbol = '0;
                                out_item_next.last       = 1'b1;
                                out_item_next.empty_res  = 1'b1;
                                out_item_next.truncated  = ovf_reg;
                                out_valid_next           = 1'b1;
                                state_next               = ST_HOLD;
                            end
                            else
                            begin
                                clr        = 1'b1;
                                t_next     = '0;
                                state_next = ST_FILL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                t_next = t_reg + T_W'(1);
                if (t_reg == fill_end)
                begin
                    count_next = final_score;
                    if (final_score == '0)
                    begin
                        out_item_next.out_symbol = '0;
                        out_item_next.last       = 1'b1;
                        out_item_next.empty_res  = 1'b1;
                        out_item_next.truncated  = ovf_reg;
                        out_valid_next           = 1'b1;
                        state_next               = ST_HOLD;
                    end
                    else
                    begin
                        ti_next    = IDX_W'(la_reg - LEN_W'(1));
                        tj_next    = IDX_W'(lb_reg - LEN_W'(1));
                        k_next     = final_score;
                        state_next = ST_TR_RD;
                    end
                end
            end
            ST_TR_RD:
            begin
                state_next = ST_TR_STEP;
            end
            ST_TR_STEP:
            begin
                state_next = ST_TR_RD;
                case (cur_dir)
                    DIR_MATCH:
                    begin
                        if (k_reg != '0)
                        begin
                            ans_we = 1'b1;
                            k_next = k_reg - LEN_W'(1);
                        end
                        if ((ti_reg == '0) || (tj_reg == '0))
                        begin
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            ti_next = ti_reg - IDX_W'(1);
                            tj_next = tj_reg - IDX_W'(1);
                        end
                    end
                    DIR_FIRST:
                    begin
                        if (ti_reg == '0)
                        begin
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            ti_next = ti_reg - IDX_W'(1);
                        end
                    end
                    default:
                    begin
                        if (tj_reg == '0)
                        begin
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            tj_next = tj_reg - IDX_W'(1);
                        end
                    end
                endcase
                if (state_next == ST_EMIT_RD)
                begin
                    emit_idx_next = '0;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_PUT;
            end
            ST_EMIT_PUT:
            begin
                out_item_next.out_symbol = ans_rd_data_reg;
                out_item_next.last       = ((LEN_W'(emit_idx_reg) + LEN_W'(1)) == count_reg);
                out_item_next.empty_res  = 1'b0;
                out_item_next.truncated  = ovf_reg;
                out_valid_next           = 1'b1;
                state_next               = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (out_item_reg.last)
                    begin
                        // The run is over: the next loads start a fresh job.
                        la_next    = '0;
                        lb_next    = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + IDX_W'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            la_reg         <= '0;
            lb_reg         <= '0;
            ovf_reg        <= 1'b0;
            t_reg          <= '0;
            ti_reg         <= '0;
            tj_reg         <= '0;
            k_reg          <= '0;
            count_reg      <= '0;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            feed_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            la_reg         <= la_next;
            lb_reg         <= lb_next;
            ovf_reg        <= ovf_next;
            t_reg          <= t_next;
            ti_reg         <= ti_next;
            tj_reg         <= tj_next;
            k_reg          <= k_next;
            count_reg      <= count_next;
            emit_idx_reg   <= emit_idx_next;
            out_valid_reg  <= out_valid_next;
            feed_valid_reg <= feed_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        feed_row_reg <= t_reg[IDX_W-1:0];
        if (a_we)
        begin
            a_mem[la_reg[IDX_W-1:0]] <= in_item.symbol;
        end
        a_rd_data_reg <= a_mem[a_rd_addr];
        if (ans_we)
        begin
            ans_mem[ans_wr_addr] <= a_rd_data_reg;
        end
        ans_rd_data_reg <= ans_mem[emit_idx_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### hdl/lcs_checker.sv
// Port-level checker for the longest common subsequence engine, bound to the top level.
module lcs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input lcs_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_stall,
    input lcs_pkg::out_item_t out_item
);
    import lcs_pkg::*;

    // A stalled result item holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result item changed");

    // Accepting a compute item makes the block busy in the next cycle.
    a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_item.opcode == OP_COMPUTE) |=> in_stall)
        else $error("input not stalled after compute");

    // No input item is taken while a result item is on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    // An empty answer is a single final item with a zero symbol.
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.empty_res |-> out_item.last && (out_item.out_symbol == '0))
        else $error("malformed empty result");

endmodule

bind longest_common_subsequence_top lcs_checker u_lcs_checker (.*);

### tb/sv/tb_longest_common_subsequence_top.sv
// Self-checking testbench for the longest common subsequence engine.
`timescale 1ns / 100ps

module tb_longest_common_subsequence_top;

    import lcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    // Predictor state: the two strings as loaded, their lengths and the overflow flag.
    logic [7:0] first_str[MAX_LEN];
    logic [7:0] second_str[MAX_LEN];
    int         first_len;
    int         second_len;
    logic       overflow_flag;

    // Expected result items, oldest first.
    out_item_t  expected_results[$];

    int         error_count;
    int         idle_cycles;
    int         stall_left;
    bit         hold_output;
    bit         stimulus_done;

    longest_common_subsequence_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly short gaps, now and then a long one, and runs with none at all.
    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Works out the subsequence of the two loaded strings by the score table, with the
    // direction marks kept per cell, and queues the result items it yields. Ties on a
    // mismatch step back in the first string, and the first column carries the score of
    // the row above.
    task automatic predict_subsequence();
        logic [6:0] prev_row[MAX_LEN];
        logic [6:0] this_row[MAX_LEN];
        dir_t       marks[MAX_LEN][MAX_LEN];
        logic [7:0] answer[MAX_LEN];
        logic [6:0] up_score;
        logic [6:0] left_score;
        logic [6:0] diag_score;
        int         count;
        int         ti;
        int         tj;
        int         k;
        out_item_t  res;
        count = 0;
        if (first_len != 0 && second_len != 0)
        begin
            for (int j = 0; j < MAX_LEN; j++)
                this_row[j] = '0;
            for (int i = 0; i < first_len; i++)
            begin
                prev_row = this_row;
                for (int j = 0; j < second_len; j++)
                begin
                    up_score   = prev_row[j];
                    left_score = (j != 0) ? this_row[j-1] : 7'd0;
                    diag_score = (j != 0) ? prev_row[j-1] : 7'd0;
                    if (first_str[i] == second_str[j])
                    begin
                        marks[i][j] = DIR_MATCH;
                        this_row[j] = diag_score + 7'd1;
                    end
                    else if (up_score < left_score)
                    begin
                        marks[i][j] = DIR_SECOND;
                        this_row[j] = left_score;
                    end
                    else
                    begin
                        marks[i][j] = DIR_FIRST;
                        this_row[j] = up_score;
                    end
                end
            end
            count = this_row[second_len-1];
            if (count > MAX_LEN)
                count = MAX_LEN;
            ti = first_len - 1;
            tj = second_len - 1;
            k  = count;
            while (ti >= 0 && tj >= 0)
            begin
                if (marks[ti][tj] == DIR_MATCH)
                begin
                    if (k > 0)
                    begin
                        k--;
                        answer[k] = first_str[ti];
                    end
                    ti--;
                    tj--;
                end
                else if (marks[ti][tj] == DIR_FIRST)
                    ti--;
                else
                    tj--;
            end
        end
        if (count == 0)
        begin
            res.out_symbol = '0;
            res.last       = 1'b1;
            res.empty_res  = 1'b1;
            res.truncated  = overflow_flag;
            expected_results.push_back(res);
        end
        else
        begin
            for (int j = 0; j < count; j++)
            begin
                res.out_symbol = answer[j];
                res.last       = (j + 1 == count);
                res.empty_res  = 1'b0;
                res.truncated  = overflow_flag;
                expected_results.push_back(res);
            end
        end
        first_len     = 0;
        second_len    = 0;
        overflow_flag = 1'b0;
    endtask

    // Updates the predictor for one accepted input item.
    task automatic predict_item(input in_item_t item);
        case (item.opcode)
            OP_LOAD_A:
                if (first_len >= MAX_LEN)
                    overflow_flag = 1'b1;
                else
                begin
                    first_str[first_len] = item.symbol;
                    first_len++;
                end
            OP_LOAD_B:
                if (second_len >= MAX_LEN)
                    overflow_flag = 1'b1;
                else
                begin
                    second_str[second_len] = item.symbol;
                    second_len++;
                end
            OP_COMPUTE:
                predict_subsequence();
            default:
                ;
        endcase
    endtask

    // Offers one item after an optional gap and waits until the block takes it. Valid is
    // left high at the end; the next call either changes the payload or lowers it.
    task automatic send_item(input logic [1:0] opcode, input logic [7:0] symbol,
                             input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        in_item.opcode <= opcode;
        in_item.symbol <= symbol;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item('{opcode: opcode, symbol: symbol});
        @(negedge clk);
    endtask

    task automatic load_string(input logic [1:0] opcode, input logic [7:0] text[$]);
        foreach (text[n])
            send_item(opcode, text[n], random_gap());
    endtask

    // Waits with valid low until every expected result has arrived.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Extremes of the symbol field, an empty first string, an empty second string, one
    // string with no match, the unused opcode and a single matching symbol.
    task automatic test_directed_edges();
        send_item(OP_COMPUTE, 8'h00, 0);
        send_item(OP_LOAD_A, 8'hFF, 0);
        send_item(OP_COMPUTE, 8'hA5, 0);
        send_item(OP_LOAD_B, 8'h00, 0);
        send_item(OP_COMPUTE, 8'h00, 0);
        send_item(OP_LOAD_A, 8'h00, 1);
        send_item(OP_UNUSED, 8'hFF, 0);
        send_item(OP_LOAD_B, 8'hFF, 0);
        send_item(OP_COMPUTE, 8'h5A, 0);
        send_item(OP_LOAD_A, 8'hFF, 0);
        send_item(OP_UNUSED, 8'h00, 0);
        send_item(OP_LOAD_B, 8'hFF, 0);
        send_item(OP_COMPUTE, 8'hFF, 0);
        // Tie on mismatch: "AB" against "BA" should keep the first-string step back.
        send_item(OP_LOAD_A, 8'h41, 0);
        send_item(OP_LOAD_A, 8'h42, 0);
        send_item(OP_LOAD_B, 8'h42, 0);
        send_item(OP_LOAD_B, 8'h41, 0);
        send_item(OP_COMPUTE, 8'h00, 0);
        drain_results();
    endtask

    // Both strings filled to the limit and beyond, so the overflow flag is set and the
    // answer runs to its full length. The receiver holds off meanwhile, so result items wait under stall.
    task automatic test_full_strings();
        logic [7:0] text[$];
        for (int n = 0; n < MAX_LEN + 2; n++)
            text.push_back(8'(n * 7));
        load_string(OP_LOAD_A, text);
        load_string(OP_LOAD_B, text);
        send_item(OP_COMPUTE, 8'h00, 0);
        hold_output = 1'b1;
        send_item(OP_LOAD_A, 8'h11, 0);
        send_item(OP_LOAD_B, 8'h11, 0);
        send_item(OP_COMPUTE, 8'h00, 0);
        drain_results();
    endtask

    // Random jobs: short strings over a small alphabet so that matches are common, with
    // an occasional long string, a wide alphabet, a stray unused opcode or an overflow.
    task automatic test_random_jobs(input int item_budget);
        int         sent;
        int         len_a;
        int         len_b;
        int         alphabet;
        logic [7:0] text[$];
        sent = 0;
        while (sent < item_budget)
        begin
            alphabet = ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(2, 6);
            len_a = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 66)
                                                 : $urandom_range(0, 8);
            len_b = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 66)
                                                 : $urandom_range(0, 8);
            text.delete();
            for (int n = 0; n < len_a; n++)
                text.push_back(8'($urandom_range(0, alphabet - 1)));
            load_string(OP_LOAD_A, text);
            text.delete();
            for (int n = 0; n < len_b; n++)
                text.push_back(8'($urandom_range(0, alphabet - 1)));
            load_string(OP_LOAD_B, text);
            if ($urandom_range(0, 9) == 0)
                send_item(OP_UNUSED, 8'($urandom()), random_gap());
            send_item(OP_COMPUTE, 8'($urandom()), random_gap());
            sent += len_a + len_b + 1;
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // Receiver: stretches of stall of random length, or a long hold-off when asked for one.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_output)
        begin
            out_stall <= 1'b1;
            if (idle_cycles < 300)
                idle_cycles++;
            else
                hold_output = 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = random_gap();
        end
        else
            out_stall <= 1'b0;
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item with none expected: %p", out_item);
                error_count++;
            end
            else
            begin
                out_item_t want;
                want = expected_results.pop_front();
                if (out_item.out_symbol !== want.out_symbol)
                begin
                    $error("out_symbol: expected %0d, got %0d", want.out_symbol,
                           out_item.out_symbol);
                    error_count++;
                end
                if (out_item.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, out_item.last);
                    error_count++;
                end
                if (out_item.empty_res !== want.empty_res)
                begin
                    $error("empty_res: expected %0d, got %0d", want.empty_res,
                           out_item.empty_res);
                    error_count++;
                end
                if (out_item.truncated !== want.truncated)
                begin
                    $error("truncated: expected %0d, got %0d", want.truncated,
                           out_item.truncated);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles with no item accepted on either side.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || stimulus_done)
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        out_stall     = 1'b0;
        error_count   = 0;
        idle_cycles   = 0;
        stall_left    = 0;
        hold_output   = 1'b0;
        stimulus_done = 1'b0;
        first_len     = 0;
        second_len    = 0;
        overflow_flag = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_full_strings();
        test_random_jobs(200);

        // Allow the engine to settle after the final result, within a bound.
        stimulus_done = 1'b1;
        repeat (400) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
hdl/lcs_pkg.sv
hdl/lcs_cell.sv
hdl/longest_common_subsequence_top.sv
hdl/lcs_checker.sv
tb/sv/tb_longest_common_subsequence_top.sv
